// File: sv/folc_pkg.sv
package folc_pkg;

  // default configuration
  localparam int DEPTH_DEF     = 16;
  localparam int FREQ_BITS_DEF = 16;

  // field widths
  localparam int OPCODE_W   = 2;
  localparam int KEY_W      = 32;
  localparam int POS_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int OUT_FREQ_W = 16;

  // stream payload widths, padded to whole bytes
  localparam int IN_FIELDS_W   = OPCODE_W + KEY_W + POS_W;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = STATUS_W + KEY_W + OUT_FREQ_W + POS_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 2'd0,
    OP_LOCATE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // outcome of the shared compare unit
  typedef struct packed {
    logic key_eq;   // a and b hold the same key
    logic a_first;  // entry a must stand ahead of entry b
  } cmp_res_t;

endpackage

// File: sv/frequency_ordered_list_core.sv
// Frequency-ordered key table. Holds up to DEPTH 32-bit keys, kept in non-increasing
// order of access count; ties go to the entry that was first located earlier, and entries
// never located stay in load order behind all others. Each input transfer carries one
// command and gives exactly one result transfer. Locate walks the table from the head
// through one shared compare unit, one entry per cycle, and then moves the hit toward the
// head one slot per cycle. The pace of the walk is set by the single read port of the
// entry memory. The block takes no new command while one is in progress; a finished
// result waits in the output register while the next command is accepted.
module frequency_ordered_list_core
  import folc_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // opcode [1:0], key [33:2], position [37:34], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status [1:0], result_key [33:2], frequency [49:34], result_position [53:50], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int AW  = $clog2(DEPTH);        // entry index
  localparam int CW  = $clog2(DEPTH + 1);    // entry count
  localparam int SW  = $clog2(DEPTH + 2);    // first-access sequence number
  localparam int EW  = KEY_W + FREQ_BITS + SW;
  localparam int PAD = OUT_TDATA_W - OUT_FIELDS_W;
  localparam logic [FREQ_BITS-1:0] FREQ_MAX = {FREQ_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MOVE,
    S_PLACE,
    S_READ,
    S_EMIT
  } state_t;

  state_t state;

  // input fields
  opcode_t          in_op;
  logic [KEY_W-1:0] in_key;
  logic [POS_W-1:0] in_pos;
  logic             in_xfer;

  assign in_op   = opcode_t'(s_axis_tdata[OPCODE_W-1:0]);
  assign in_key  = s_axis_tdata[OPCODE_W +: KEY_W];
  assign in_pos  = s_axis_tdata[OPCODE_W + KEY_W +: POS_W];
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  // table state
  logic [CW-1:0] entry_count;
  logic [SW-1:0] next_seq;
  logic [AW-1:0] cur;           // entry under test / slot being filled

  // latched search key and the entry being moved toward the head
  logic [KEY_W-1:0]     key_r;
  logic [KEY_W-1:0]     h_key;
  logic [FREQ_BITS-1:0] h_freq;
  logic [SW-1:0]        h_seq;

  // result waiting for the output register
  status_t              res_status;
  logic [KEY_W-1:0]     res_key;
  logic [OUT_FREQ_W-1:0] res_freq;
  logic [POS_W-1:0]     res_pos;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  logic [KEY_W-1:0]     rd_key;
  logic [FREQ_BITS-1:0] rd_freq;
  logic [SW-1:0]        rd_seq;

  assign rd_key  = mem_rdata[KEY_W-1:0];
  assign rd_freq = mem_rdata[KEY_W +: FREQ_BITS];
  assign rd_seq  = mem_rdata[KEY_W + FREQ_BITS +: SW];

  folc_mem #(
    .WIDTH (EW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // shared compare: key match while searching, ordering while moving
  cmp_res_t cmp;

  folc_cmp #(
    .FREQ_BITS (FREQ_BITS),
    .SW        (SW)
  ) u_cmp (
    .a_key  (key_r),
    .a_freq (h_freq),
    .a_seq  (h_seq),
    .b_key  (rd_key),
    .b_freq (rd_freq),
    .b_seq  (rd_seq),
    .res    (cmp)
  );

  // hit entry after its access is counted
  logic                 first_hit;
  logic [SW-1:0]        upd_seq;
  logic [FREQ_BITS-1:0] upd_freq;

  assign first_hit = (rd_freq == '0) && (rd_seq == '0);
  assign upd_seq   = first_hit ? next_seq : rd_seq;
  assign upd_freq  = (rd_freq == FREQ_MAX) ? rd_freq : rd_freq + FREQ_BITS'(1);

  logic last_entry;
  logic table_full;
  logic pos_bad;

  assign last_entry = ((CW'(cur) + CW'(1)) == entry_count);
  assign table_full = (32'(entry_count) >= 32'(DEPTH));
  assign pos_bad    = (32'(in_pos) >= 32'(entry_count));

  // result fields already known when a command is accepted
  status_t          cmd_status;
  logic [KEY_W-1:0] cmd_key;
  logic [POS_W-1:0] cmd_pos;

  always_comb begin
    cmd_status = ST_OK;
    cmd_key    = '0;
    cmd_pos    = '0;
    unique case (in_op)
      OP_APPEND: begin
        if (table_full) begin
          cmd_status = ST_FULL;
        end else begin
          cmd_key = in_key;
          cmd_pos = POS_W'(entry_count);
        end
      end
      OP_LOCATE: begin
        if (entry_count == '0) begin
          cmd_status = ST_MISS;
        end
      end
      OP_READ: begin
        if (pos_bad) begin
          cmd_status = ST_RANGE;
        end else begin
          cmd_pos = in_pos;
        end
      end
      default: begin
        cmd_status = ST_OK;
      end
    endcase
  end

  // output register loads when free or being drained
  logic out_load;

  assign out_load = (state == S_EMIT) && (!m_axis_tvalid || m_axis_tready);

  // memory control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = {h_seq, h_freq, h_key};
    mem_raddr = cur;
    unique case (state)
      S_IDLE: begin
        mem_waddr = entry_count[AW-1:0];
        mem_wdata = {SW'(0), FREQ_BITS'(0), in_key};
        mem_we    = in_xfer && (in_op == OP_APPEND) && !table_full;
        mem_raddr = (in_op == OP_READ) ? AW'(in_pos) : '0;
      end
      S_SEARCH: begin
        // a hit at the head is written back in place
        mem_wdata = {upd_seq, upd_freq, rd_key};
        mem_we    = cmp.key_eq && (cur == '0);
        mem_raddr = cmp.key_eq ? cur - AW'(1) : cur + AW'(1);
      end
      S_MOVE: begin
        // the entry ahead slides back one slot, or the moving entry settles here
        mem_we    = 1'b1;
        mem_wdata = cmp.a_first ? mem_rdata : {h_seq, h_freq, h_key};
        mem_raddr = cur - AW'(2);
      end
      S_PLACE: begin
        mem_we = 1'b1;
      end
      S_READ, S_EMIT: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= '0;
      next_seq      <= SW'(1);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            key_r      <= in_key;
            res_status <= cmd_status;
            res_key    <= cmd_key;
            res_freq   <= '0;
            res_pos    <= cmd_pos;
            cur        <= '0;
            unique case (in_op)
              OP_APPEND: begin
                if (!table_full) begin
                  entry_count <= entry_count + CW'(1);
                end
                state <= S_EMIT;
              end
              OP_LOCATE: begin
                state <= (entry_count == '0) ? S_EMIT : S_SEARCH;
              end
              OP_READ: begin
                state <= pos_bad ? S_EMIT : S_READ;
              end
              OP_CLEAR: begin
                entry_count <= '0;
                next_seq    <= SW'(1);
                state       <= S_EMIT;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (cmp.key_eq) begin
            h_key  <= rd_key;
            h_freq <= upd_freq;
            h_seq  <= upd_seq;
            if (first_hit) begin
              next_seq <= next_seq + SW'(1);
            end
            if (cur == '0) begin
              res_key  <= rd_key;
              res_freq <= OUT_FREQ_W'(upd_freq);
              res_pos  <= '0;
              state    <= S_EMIT;
            end else begin
              state <= S_MOVE;
            end
          end else if (last_entry) begin
            res_status <= ST_MISS;
            state      <= S_EMIT;
          end else begin
            cur <= cur + AW'(1);
          end
        end
        S_MOVE: begin
          if (cmp.a_first) begin
            cur <= cur - AW'(1);
            if (cur == AW'(1)) begin
              state <= S_PLACE;
            end
          end else begin
            res_key  <= h_key;
            res_freq <= OUT_FREQ_W'(h_freq);
            res_pos  <= POS_W'(cur);
            state    <= S_EMIT;
          end
        end
        S_PLACE: begin
          res_key  <= h_key;
          res_freq <= OUT_FREQ_W'(h_freq);
          res_pos  <= POS_W'(cur);
          state    <= S_EMIT;
        end
        S_READ: begin
          res_key  <= rd_key;
          res_freq <= OUT_FREQ_W'(rd_freq);
          state    <= S_EMIT;
        end
        S_EMIT: begin
          // load the output register once it is free or being drained
          if (out_load) begin
            m_axis_tdata <= {PAD'(0), res_pos, res_freq, res_key, res_status};
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the table never holds more entries than it has slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(entry_count) <= 32'(DEPTH))
    else $error("entry count beyond table depth");

  // each first access belongs to a distinct stored entry
  a_seq_bound: assert property (@(posedge clk) disable iff (rst)
    32'(next_seq) <= 32'(entry_count) + 32'd1)
    else $error("sequence number ran ahead of entry count");

  // the table is written only by an accepted append or during a locate
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (in_xfer && in_op == OP_APPEND) || state == S_SEARCH
               || state == S_MOVE || state == S_PLACE)
    else $error("memory write outside append or locate");

  // a result leaves the sequencer only into a free or draining output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && m_axis_tvalid && !m_axis_tready) |=> state == S_EMIT)
    else $error("result dropped while output stalled");

endmodule

// File: sv/folc_mem.sv
module folc_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/folc_cmp.sv
module folc_cmp
  import folc_pkg::*;
#(
  parameter int FREQ_BITS = FREQ_BITS_DEF,
  parameter int SW        = 5
) (
  input  logic [KEY_W-1:0]     a_key,
  input  logic [FREQ_BITS-1:0] a_freq,
  input  logic [SW-1:0]        a_seq,
  input  logic [KEY_W-1:0]     b_key,
  input  logic [FREQ_BITS-1:0] b_freq,
  input  logic [SW-1:0]        b_seq,
  output cmp_res_t             res
);

  // higher frequency first, then earlier first access
  always_comb begin
    res.key_eq = (a_key == b_key);
    if (a_freq != b_freq) begin
      res.a_first = (a_freq > b_freq);
    end else begin
      res.a_first = (a_seq < b_seq);
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import folc_pkg::*;

  localparam int     DEPTH        = DEPTH_DEF;
  localparam int     FREQ_BITS    = FREQ_BITS_DEF;
  localparam longint FREQ_MAX     = (longint'(1) << FREQ_BITS) - 1;
  localparam int     TIE_LOCATES  = (FREQ_MAX < 40) ? int'(FREQ_MAX) : 40;
  localparam int     LIMIT_CYCLES = 3_000_000;
  localparam int     DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     RANDOM_ITEMS = 1000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // opcode, key, position, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // status, result_key, frequency, result_position, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  typedef struct {
    status_t                 status;
    logic [KEY_W-1:0]        key;
    logic [OUT_FREQ_W-1:0]   freq;
    logic [POS_W-1:0]        pos;
  } reply_t;

  reply_t pending_replies[$];

  // shadow copy of the key table
  logic [KEY_W-1:0] shadow_key   [DEPTH];
  longint unsigned  shadow_freq  [DEPTH];
  int               shadow_first [DEPTH];
  int               shadow_count = 0;
  int               shadow_seq   = 1;

  logic [KEY_W-1:0] key_pool [12];

  int   fail_count  = 0;
  int   cycle_count = 0;
  logic idle_on     = 1'b1;
  logic rx_hold     = 1'b0;

  frequency_ordered_list_core #(
    .DEPTH     (DEPTH),
    .FREQ_BITS (FREQ_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // entry a has to stand ahead of entry b
  function automatic bit stands_ahead(int a, int b);
    if (shadow_freq[a] != shadow_freq[b])
      return shadow_freq[a] > shadow_freq[b];
    return shadow_first[a] < shadow_first[b];
  endfunction

  // update the shadow table with one command and return the reply it gives
  function automatic reply_t apply_command(opcode_t op, logic [KEY_W-1:0] key,
                                           logic [POS_W-1:0] pos);
    reply_t           r;
    int               i;
    logic [KEY_W-1:0] tk;
    longint unsigned  tf;
    int               ta;
    r.status = ST_OK;
    r.key    = '0;
    r.freq   = '0;
    r.pos    = '0;
    case (op)
      OP_APPEND: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_key[shadow_count]   = key;
          shadow_freq[shadow_count]  = 0;
          shadow_first[shadow_count] = 0;
          r.key = key;
          r.pos = POS_W'(shadow_count);
          shadow_count++;
        end
      end
      OP_LOCATE: begin
        i = 0;
        while (i < shadow_count && shadow_key[i] !== key) i++;
        if (i >= shadow_count) begin
          r.status = ST_MISS;
        end else begin
          // first hit gets the next first-access number
          if (shadow_freq[i] == 0 && shadow_first[i] == 0) begin
            shadow_first[i] = shadow_seq;
            shadow_seq++;
          end
          if (shadow_freq[i] < FREQ_MAX) shadow_freq[i]++;
          while (i > 0 && stands_ahead(i, i - 1)) begin
            tk = shadow_key[i];   shadow_key[i]   = shadow_key[i-1];   shadow_key[i-1]   = tk;
            tf = shadow_freq[i];  shadow_freq[i]  = shadow_freq[i-1];  shadow_freq[i-1]  = tf;
            ta = shadow_first[i]; shadow_first[i] = shadow_first[i-1]; shadow_first[i-1] = ta;
            i--;
          end
          r.key  = shadow_key[i];
          r.freq = OUT_FREQ_W'(shadow_freq[i]);
          r.pos  = POS_W'(i);
        end
      end
      OP_READ: begin
        if (pos >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          r.key  = shadow_key[pos];
          r.freq = OUT_FREQ_W'(shadow_freq[pos]);
          r.pos  = pos;
        end
      end
      default: begin
        shadow_count = 0;
        shadow_seq   = 1;
      end
    endcase
    return r;
  endfunction

  // offer one command, leave tvalid high once it is taken
  task automatic send_command(opcode_t op, logic [KEY_W-1:0] key, logic [POS_W-1:0] pos);
    int gap;
    if (idle_on && $urandom_range(0, 99) < 9) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, pos, key, op};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    pending_replies.push_back(apply_command(op, key, pos));
  endtask

  // result side: compare each transfer with the oldest pending reply
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $error("result transfer with no command pending: tdata %0h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata[0 +: STATUS_W] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[0 +: STATUS_W]);
          fail_count++;
        end
        if (m_axis_tdata[STATUS_W +: KEY_W] !== want.key) begin
          $error("result_key: expected %0h, got %0h", want.key,
                 m_axis_tdata[STATUS_W +: KEY_W]);
          fail_count++;
        end
        if (m_axis_tdata[STATUS_W + KEY_W +: OUT_FREQ_W] !== want.freq) begin
          $error("frequency: expected %0d, got %0d", want.freq,
                 m_axis_tdata[STATUS_W + KEY_W +: OUT_FREQ_W]);
          fail_count++;
        end
        if (m_axis_tdata[STATUS_W + KEY_W + OUT_FREQ_W +: POS_W] !== want.pos) begin
          $error("result_position: expected %0d, got %0d", want.pos,
                 m_axis_tdata[STATUS_W + KEY_W + OUT_FREQ_W +: POS_W]);
          fail_count++;
        end
      end
    end
    m_axis_tready <= !rx_hold && !(idle_on && $urandom_range(0, 99) < 9);
  end

  function automatic logic [KEY_W-1:0] fill_key(int i);
    case (i)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4, 5:    return 32'h0000_0001;  // duplicate, locate takes the first one
      default: return 32'h2468_ACE0 + i * 32'h0101_0101;
    endcase
  endfunction

  task automatic test_empty_table;
    send_command(OP_READ, '0, '0);
    send_command(OP_LOCATE, 32'h8000_0000, 4'hF);
    send_command(OP_CLEAR, 32'hFFFF_FFFF, 4'hF);
  endtask

  task automatic test_fill_and_overflow;
    for (int i = 0; i < DEPTH; i++) send_command(OP_APPEND, fill_key(i), POS_W'(i));
    send_command(OP_APPEND, 32'hDEAD_BEEF, '0);  // table full
    send_command(OP_READ, '0, 4'hF);
    send_command(OP_READ, '0, 4'h0);
  endtask

  task automatic test_locate_order;
    send_command(OP_LOCATE, 32'h0000_0001, '0);       // jumps over unvisited entries
    send_command(OP_LOCATE, 32'h8000_0000, '0);       // stops behind the earlier tie
    send_command(OP_LOCATE, fill_key(DEPTH - 1), '0); // tail entry
    send_command(OP_LOCATE, 32'h8000_0000, '0);       // higher count, to the head
    send_command(OP_READ, '0, 4'd5);
  endtask

  // b pulls ahead of a, then a catches up and wins the tie by earlier first access;
  // with a narrow count both saturate on the way
  task automatic test_equal_count_tie;
    idle_on <= 1'b0;
    send_command(OP_CLEAR, '0, '0);
    send_command(OP_APPEND, 32'h5A5A_A5A5, '0);
    send_command(OP_APPEND, 32'hA5A5_5A5A, '0);
    send_command(OP_LOCATE, 32'h5A5A_A5A5, '0);
    repeat (TIE_LOCATES + 1) send_command(OP_LOCATE, 32'hA5A5_5A5A, '0);
    repeat (TIE_LOCATES) send_command(OP_LOCATE, 32'h5A5A_A5A5, '0);
    send_command(OP_READ, '0, 4'd0);
    send_command(OP_READ, '0, 4'd1);
    idle_on <= 1'b1;
  endtask

  // receiver stops for a long stretch while commands keep coming
  task automatic test_output_stall;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      repeat (24)
        send_command(opcode_t'($urandom_range(0, 3)), $urandom, POS_W'($urandom));
    join
  endtask

  task automatic test_random_traffic(int n_items);
    int               roll;
    opcode_t          op;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    foreach (key_pool[j]) key_pool[j] = $urandom;
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 3) idle_on <= 1'b0;
      if (k == n_items / 2) idle_on <= 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 3)       op = OP_CLEAR;
      else if (roll < 28) op = OP_APPEND;
      else if (roll < 75) op = OP_LOCATE;
      else                op = OP_READ;
      // keys mostly from the pool or the table so locates hit
      roll = $urandom_range(0, 99);
      if (op == OP_LOCATE && shadow_count > 0 && roll < 70)
        key = shadow_key[$urandom_range(0, shadow_count - 1)];
      else if (roll < 85)
        key = key_pool[$urandom_range(0, 11)];
      else
        key = $urandom;
      if (shadow_count > 0 && $urandom_range(0, 1))
        pos = POS_W'($urandom_range(0, shadow_count - 1));
      else
        pos = POS_W'($urandom_range(0, 15));
      send_command(op, key, pos);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_fill_and_overflow();
    test_locate_order();
    test_equal_count_tie();
    test_output_stall();
    test_random_traffic(RANDOM_ITEMS);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
